FILE: hdl/moving_average_cross_signal_top_macros.svh
// assertion macros for the rtl top module
`ifndef MOVING_AVERAGE_CROSS_SIGNAL_TOP_MACROS_SVH
`define MOVING_AVERAGE_CROSS_SIGNAL_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define MACS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MACS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MACS_ASSERT(label, clk, rst_n, prop, msg)
`define MACS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: hdl/macs_pkg.sv
package macs_pkg;

    localparam int PRICE_BITS = 32;
    localparam int PERIOD_W   = 7;

    // signal codes
    localparam logic [1:0] SIG_NONE = 2'd0;
    localparam logic [1:0] SIG_BUY  = 2'd1;
    localparam logic [1:0] SIG_SELL = 2'd2;
    localparam logic [1:0] SIG_HOLD = 2'd3;

    // register indexes (word address bit)
    localparam logic REG_FAST_LEN = 1'b0;
    localparam logic REG_SLOW_LEN = 1'b1;

    localparam logic [PERIOD_W-1:0] FAST_LEN_RST = 7'd5;
    localparam logic [PERIOD_W-1:0] SLOW_LEN_RST = 7'd20;

    typedef struct packed {
        logic [PRICE_BITS-1:0] close_price;
        logic                  pos_held;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            signal;
        logic [PRICE_BITS-1:0] fast_avg;
        logic [PRICE_BITS-1:0] slow_avg;
    } t_out_item;

endpackage

FILE: hdl/moving_average_cross_signal_top.sv
// moving average crossover signal generator
// input channel: i_in_valid / o_in_stall carry one bar (close price in unsigned
//   Q24.8 and a position-held flag); a transfer happens when valid is high and
//   stall is low
// output channel: o_out_valid / i_out_stall carry one result per bar: the
//   signal code (none, buy, sell, hold) and the latest fast and slow averages
// config: apb-style port, fast window length at byte 0, slow at byte 4
// timing: one bar at a time; the ring pass sums the newest L prices, L being
//   the larger effective period, capped by the prices seen, at most MAX_PERIOD,
//   with one read per cycle; then two restoring divisions of 39 steps run on
//   one shared subtractor, and a window not yet filled skips its division;
//   the next bar can transfer in the cycle after the result is loaded
// stall stays high from a transfer until the result is loaded into the
//   output register; a finished result may wait there while the next bar is
//   taken, and the sequencer only waits when a new result meets a full,
//   stalled output register
// reset: synchronous active low; clears counters, averages, last signal and
//   restores period defaults (5 and 20); ring contents are never cleared,
//   only written entries are ever read
`include "moving_average_cross_signal_top_macros.svh"

module moving_average_cross_signal_top #(
    parameter int MAX_PERIOD = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  macs_pkg::t_in_item   i_in_data,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output macs_pkg::t_out_item  o_out_data,
    // config port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int PW     = macs_pkg::PRICE_BITS;
    localparam int PERW   = macs_pkg::PERIOD_W;
    localparam int IDX_W  = $clog2(MAX_PERIOD);
    localparam int SEEN_W = $clog2(MAX_PERIOD + 1);
    // window sum width, wide enough for 127 prices
    localparam int SUM_W  = PW + PERW;
    localparam int DCNT_W = $clog2(SUM_W);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_LOAD = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    // zero acts as one, above the ring depth acts as the ring depth
    function automatic logic [PERW-1:0] eff_period(input logic [PERW-1:0] p);
        logic [PERW-1:0] e;
        if (p == '0) begin
            e = PERW'(1);
        end else if (32'(p) > MAX_PERIOD) begin
            e = PERW'(MAX_PERIOD);
        end else begin
            e = p;
        end
        return e;
    endfunction

    // config registers
    logic [PERW-1:0] r_fast_len, r_slow_len;

    // sequencer and item state
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_wslot, n_wslot;
    logic [SEEN_W-1:0]  r_seen, n_seen;
    logic               r_hold, n_hold;
    logic [PERW-1:0]    r_pf, n_pf, r_ps, n_ps;
    logic [SEEN_W-1:0]  r_len, n_len;

    // ring read pass
    logic [IDX_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [SEEN_W-1:0]  r_rd_cnt, n_rd_cnt;
    logic [SEEN_W-1:0]  r_rd_i, n_rd_i;
    logic               r_rd_vld, n_rd_vld;
    logic [PW-1:0]      r_rd_data;
    logic [SUM_W-1:0]   r_acc, n_acc;
    logic [SUM_W-1:0]   r_fast_sum, n_fast_sum;
    logic [SUM_W-1:0]   r_slow_sum, n_slow_sum;

    // shared divider
    logic               r_div_sel, n_div_sel;
    logic [SUM_W-1:0]   r_div_q, n_div_q;
    logic [PERW-1:0]    r_div_r, n_div_r;
    logic [PERW-1:0]    r_div_d, n_div_d;
    logic [DCNT_W-1:0]  r_div_cnt, n_div_cnt;

    // averages and signal history
    logic [PW-1:0]      r_fast_old, n_fast_old, r_fast_cur, n_fast_cur;
    logic [PW-1:0]      r_slow_old, n_slow_old, r_slow_cur, n_slow_cur;
    logic [1:0]         r_fast_cnt, n_fast_cnt, r_slow_cnt, n_slow_cnt;
    logic [1:0]         r_last_sig, n_last_sig;

    // output register
    logic                 r_out_valid, n_out_valid;
    macs_pkg::t_out_item  r_out_data, n_out_data;

    // price ring
    logic [PW-1:0] mem_ring [MAX_PERIOD];

    logic in_xfer;
    logic cfg_wr;
    logic [SEEN_W-1:0] seen_inc;
    logic [PERW-1:0]   pf_new, ps_new, pmax;
    logic              issue;
    logic [SUM_W-1:0]  acc_sum;
    logic              do_fast, do_slow;
    logic [PERW:0]     trial;
    logic              ge;
    logic [SUM_W-1:0]  q_step;
    logic [PERW-1:0]   r_step;
    logic [1:0]        xover, sig, last_upd;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == macs_pkg::REG_SLOW_LEN) ? 32'(r_slow_len)
                                                         : 32'(r_fast_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_len <= macs_pkg::FAST_LEN_RST;
            r_slow_len <= macs_pkg::SLOW_LEN_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == macs_pkg::REG_SLOW_LEN) begin
                r_slow_len <= pwdata[PERW-1:0];
            end else begin
                r_fast_len <= pwdata[PERW-1:0];
            end
        end
    end

    // ring write on transfer, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            mem_ring[r_wslot] <= i_in_data.close_price;
        end
        r_rd_data <= mem_ring[r_rd_ptr];
    end

    assign do_fast = 32'(r_seen) >= 32'(r_pf);
    assign do_slow = 32'(r_seen) >= 32'(r_ps);

    // divider step: shift in next dividend bit, subtract when it fits
    assign trial  = {r_div_r, r_div_q[SUM_W-1]};
    assign ge     = (trial >= {1'b0, r_div_d});
    assign r_step = ge ? PERW'(trial - {1'b0, r_div_d}) : trial[PERW-1:0];
    assign q_step = {r_div_q[SUM_W-2:0], ge};

    assign seen_inc = (32'(r_seen) < MAX_PERIOD) ? r_seen + SEEN_W'(1) : r_seen;
    assign pf_new   = eff_period(r_fast_len);
    assign ps_new   = eff_period(r_slow_len);
    assign pmax     = (pf_new > ps_new) ? pf_new : ps_new;
    assign issue    = (r_rd_cnt < r_len);
    assign acc_sum  = r_acc + SUM_W'(r_rd_data);

    // crossover decision on the updated averages
    always_comb begin
        xover    = macs_pkg::SIG_NONE;
        last_upd = r_last_sig;
        if (r_fast_cnt == 2'd2 && r_slow_cnt == 2'd2) begin
            if (r_fast_old <= r_slow_old && r_fast_cur > r_slow_cur) begin
                xover = macs_pkg::SIG_BUY;
            end else if (r_fast_old >= r_slow_old && r_fast_cur < r_slow_cur) begin
                xover = macs_pkg::SIG_SELL;
            end
        end
        if (!do_slow) begin
            sig = macs_pkg::SIG_NONE;
        end else if (xover == macs_pkg::SIG_BUY && r_hold) begin
            sig = macs_pkg::SIG_HOLD;
        end else if (xover == macs_pkg::SIG_SELL && !r_hold) begin
            sig = macs_pkg::SIG_HOLD;
        end else if (xover == r_last_sig) begin
            sig = macs_pkg::SIG_HOLD;
        end else begin
            sig = xover;
            if (xover != macs_pkg::SIG_NONE) begin
                last_upd = xover;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_wslot     = r_wslot;
        n_seen      = r_seen;
        n_hold      = r_hold;
        n_pf        = r_pf;
        n_ps        = r_ps;
        n_len       = r_len;
        n_rd_ptr    = r_rd_ptr;
        n_rd_cnt    = r_rd_cnt;
        n_rd_i      = r_rd_i;
        n_rd_vld    = 1'b0;
        n_acc       = r_acc;
        n_fast_sum  = r_fast_sum;
        n_slow_sum  = r_slow_sum;
        n_div_sel   = r_div_sel;
        n_div_q     = r_div_q;
        n_div_r     = r_div_r;
        n_div_d     = r_div_d;
        n_div_cnt   = r_div_cnt;
        n_fast_old  = r_fast_old;
        n_fast_cur  = r_fast_cur;
        n_slow_old  = r_slow_old;
        n_slow_cur  = r_slow_cur;
        n_fast_cnt  = r_fast_cnt;
        n_slow_cnt  = r_slow_cnt;
        n_last_sig  = r_last_sig;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_wslot  = (32'(r_wslot) == MAX_PERIOD - 1) ? '0
                                                                : r_wslot + IDX_W'(1);
                    n_seen   = seen_inc;
                    n_hold   = i_in_data.pos_held;
                    n_pf     = pf_new;
                    n_ps     = ps_new;
                    // newest prices needed, never more than have been written
                    n_len    = (32'(pmax) < 32'(seen_inc)) ? SEEN_W'(pmax) : seen_inc;
                    n_rd_ptr = r_wslot;
                    n_rd_cnt = '0;
                    n_acc    = '0;
                    n_state  = S_SUM;
                end
            end
            S_SUM: begin
                if (issue) begin
                    n_rd_cnt = r_rd_cnt + SEEN_W'(1);
                    n_rd_ptr = (r_rd_ptr == '0) ? IDX_W'(MAX_PERIOD - 1)
                                                : r_rd_ptr - IDX_W'(1);
                    n_rd_i   = r_rd_cnt;
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld) begin
                    n_acc = acc_sum;
                    if (32'(r_rd_i) == 32'(r_pf) - 32'd1) begin
                        n_fast_sum = acc_sum;
                    end
                    if (32'(r_rd_i) == 32'(r_ps) - 32'd1) begin
                        n_slow_sum = acc_sum;
                    end
                end
                if (!issue && !r_rd_vld) begin
                    n_div_sel = 1'b0;
                    n_state   = S_LOAD;
                end
            end
            S_LOAD: begin
                n_div_r   = '0;
                n_div_cnt = '0;
                if (!r_div_sel) begin
                    n_div_q = r_fast_sum;
                    n_div_d = r_pf;
                    if (do_fast) begin
                        n_state = S_DIV;
                    end else begin
                        n_div_sel = 1'b1;
                    end
                end else begin
                    n_div_q = r_slow_sum;
                    n_div_d = r_ps;
                    n_state = do_slow ? S_DIV : S_OUT;
                end
            end
            S_DIV: begin
                n_div_q   = q_step;
                n_div_r   = r_step;
                n_div_cnt = r_div_cnt + DCNT_W'(1);
                if (32'(r_div_cnt) == SUM_W - 1) begin
                    if (!r_div_sel) begin
                        n_fast_old  = r_fast_cur;
                        n_fast_cur  = q_step[PW-1:0];
                        n_fast_cnt  = (r_fast_cnt == 2'd2) ? r_fast_cnt : r_fast_cnt + 2'd1;
                        n_div_sel   = 1'b1;
                        n_state     = S_LOAD;
                    end else begin
                        n_slow_old  = r_slow_cur;
                        n_slow_cur  = q_step[PW-1:0];
                        n_slow_cnt  = (r_slow_cnt == 2'd2) ? r_slow_cnt : r_slow_cnt + 2'd1;
                        n_state     = S_OUT;
                    end
                end
            end
            S_OUT: begin
                // wait only while the previous result is still held
                if (!(r_out_valid && i_out_stall)) begin
                    n_out_valid         = 1'b1;
                    n_out_data.signal   = sig;
                    n_out_data.fast_avg = r_fast_cur;
                    n_out_data.slow_avg = r_slow_cur;
                    n_last_sig          = last_upd;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wslot     <= '0;
            r_seen      <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_cnt    <= '0;
            r_rd_ptr    <= '0;
            r_len       <= '0;
            r_div_sel   <= 1'b0;
            r_div_cnt   <= '0;
            r_fast_old  <= '0;
            r_fast_cur  <= '0;
            r_slow_old  <= '0;
            r_slow_cur  <= '0;
            r_fast_cnt  <= '0;
            r_slow_cnt  <= '0;
            r_last_sig  <= macs_pkg::SIG_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wslot     <= n_wslot;
            r_seen      <= n_seen;
            r_rd_vld    <= n_rd_vld;
            r_rd_cnt    <= n_rd_cnt;
            r_rd_ptr    <= n_rd_ptr;
            r_len       <= n_len;
            r_div_sel   <= n_div_sel;
            r_div_cnt   <= n_div_cnt;
            r_fast_old  <= n_fast_old;
            r_fast_cur  <= n_fast_cur;
            r_slow_old  <= n_slow_old;
            r_slow_cur  <= n_slow_cur;
            r_fast_cnt  <= n_fast_cnt;
            r_slow_cnt  <= n_slow_cnt;
            r_last_sig  <= n_last_sig;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_hold     <= n_hold;
        r_pf       <= n_pf;
        r_ps       <= n_ps;
        r_rd_i     <= n_rd_i;
        r_acc      <= n_acc;
        r_fast_sum <= n_fast_sum;
        r_slow_sum <= n_slow_sum;
        r_div_q    <= n_div_q;
        r_div_r    <= n_div_r;
        r_div_d    <= n_div_d;
        r_out_data <= n_out_data;
    end

    // checks
    `MACS_ASSERT(a_xfer_starts_sum, i_clk, i_rst_n, in_xfer |=> r_state == S_SUM, "transfer did not start the ring pass")
    `MACS_ASSERT(a_fast_cnt_sat, i_clk, i_rst_n, r_fast_cnt != 2'd3, "fast average count past two")
    `MACS_ASSERT(a_last_not_hold, i_clk, i_rst_n, r_last_sig != macs_pkg::SIG_HOLD, "hold stored as last signal")
    `MACS_ASSERT(a_seen_bound, i_clk, i_rst_n, 32'(r_seen) <= MAX_PERIOD, "price count past ring depth")
    `MACS_ASSERT(a_out_from_seq, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_OUT), "result loaded outside the output step")

endmodule

FILE: tb/moving_average_cross_signal_top_tb.sv
module moving_average_cross_signal_top_tb;

    localparam int RING_DEPTH    = 64;
    // the longest bar takes a full ring pass and two divisions; leave a good margin
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 600;
    localparam logic [2:0] ADDR_FAST = {macs_pkg::REG_FAST_LEN, 2'b00};
    localparam logic [2:0] ADDR_SLOW = {macs_pkg::REG_SLOW_LEN, 2'b00};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    macs_pkg::t_in_item   i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    macs_pkg::t_out_item  o_out_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    moving_average_cross_signal_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 2 time unit clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // crossover predictor: own copy of the price history, averages and
    // the period registers
    // ------------------------------------------------------------------
    bit [31:0]   price_hist [RING_DEPTH];
    bit [5:0]    next_slot;
    bit [6:0]    bars_seen;        // saturates at the ring depth
    bit [31:0]   fast_old, fast_cur, slow_old, slow_cur;
    bit [1:0]    fast_formed, slow_formed;
    logic [1:0]  last_trade;       // last buy or sell handed out
    bit [6:0]    fast_len_reg = macs_pkg::FAST_LEN_RST;
    bit [6:0]    slow_len_reg = macs_pkg::SLOW_LEN_RST;

    macs_pkg::t_out_item pending_results[$];

    // stimulus and bookkeeping
    bit          holding_now;      // position implied by the signals so far
    bit          gaps_enabled = 1'b1;
    bit          long_hold_request;
    int unsigned hold_cycles_left;
    int unsigned errors, bars_sent, results_seen, period_writes;
    int unsigned n_buy, n_sell, n_hold, n_none;

    // zero acts as one, anything past the ring depth acts as the ring depth
    function automatic int unsigned eff_len(bit [6:0] p);
        if (p == 0) return 1;
        if (p > RING_DEPTH) return RING_DEPTH;
        return 32'(p);
    endfunction

    // sum of the newest len prices
    function automatic bit [37:0] newest_sum(int unsigned len);
        bit [37:0] acc;
        bit [5:0]  idx;
        acc = '0;
        for (int unsigned k = 0; k < len; k++) begin
            idx = next_slot - 6'd1 - 6'(k);
            acc += 38'(price_hist[idx]);
        end
        return acc;
    endfunction

    function automatic void predict_crossover(macs_pkg::t_in_item bar);
        int unsigned         pf, ps;
        bit [37:0]           quot;
        logic [1:0]          xover, sig;
        macs_pkg::t_out_item res;
        pf = eff_len(fast_len_reg);
        ps = eff_len(slow_len_reg);
        price_hist[next_slot] = bar.close_price;
        next_slot++;
        if (bars_seen < RING_DEPTH) bars_seen++;

        if (bars_seen >= pf) begin
            quot = newest_sum(pf) / 38'(pf);
            fast_old = fast_cur;
            fast_cur = quot[31:0];
            if (fast_formed < 2) fast_formed++;
        end
        if (bars_seen >= ps) begin
            quot = newest_sum(ps) / 38'(ps);
            slow_old = slow_cur;
            slow_cur = quot[31:0];
            if (slow_formed < 2) slow_formed++;
        end

        if (bars_seen < ps) begin
            sig = macs_pkg::SIG_NONE;
        end else begin
            xover = macs_pkg::SIG_NONE;
            if (fast_formed >= 2 && slow_formed >= 2) begin
                if (fast_old <= slow_old && fast_cur > slow_cur)
                    xover = macs_pkg::SIG_BUY;
                else if (fast_old >= slow_old && fast_cur < slow_cur)
                    xover = macs_pkg::SIG_SELL;
            end
            // position filter, then repeat filter
            if (xover == macs_pkg::SIG_BUY && bar.pos_held) sig = macs_pkg::SIG_HOLD;
            else if (xover == macs_pkg::SIG_SELL && !bar.pos_held) sig = macs_pkg::SIG_HOLD;
            else if (xover == last_trade) sig = macs_pkg::SIG_HOLD;
            else begin
                if (xover != macs_pkg::SIG_NONE) last_trade = xover;
                sig = xover;
            end
        end

        case (sig)
            macs_pkg::SIG_BUY: begin
                n_buy++;
                holding_now = 1'b1;
            end
            macs_pkg::SIG_SELL: begin
                n_sell++;
                holding_now = 1'b0;
            end
            macs_pkg::SIG_HOLD: n_hold++;
            default: n_none++;
        endcase

        res.signal   = sig;
        res.fast_avg = (fast_formed > 0) ? fast_cur : '0;
        res.slow_avg = (slow_formed > 0) ? slow_cur : '0;
        pending_results = {pending_results, res};
    endfunction

    // ------------------------------------------------------------------
    // output side: stall pattern and result checking
    // ------------------------------------------------------------------

    // random stall about 9 percent of cycles; a long hold when asked
    always @(posedge i_clk) begin
        if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_cycles_left = HOLD_CYCLES;
        end
        if (hold_cycles_left > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles_left--;
        end else if (gaps_enabled) begin
            i_out_stall <= ($urandom_range(99) < 9);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // every transfer on the output is compared with the oldest pending result
    always @(posedge i_clk) begin
        macs_pkg::t_out_item exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, o_out_data);
                errors++;
            end else begin
                exp_res = pending_results[0];
                pending_results.delete(0);
                if (o_out_data.signal !== exp_res.signal) begin
                    $display("%0t: signal mismatch, expected %0d actual %0d",
                             $time, exp_res.signal, o_out_data.signal);
                    errors++;
                end
                if (o_out_data.fast_avg !== exp_res.fast_avg) begin
                    $display("%0t: fast_avg mismatch, expected %h actual %h",
                             $time, exp_res.fast_avg, o_out_data.fast_avg);
                    errors++;
                end
                if (o_out_data.slow_avg !== exp_res.slow_avg) begin
                    $display("%0t: slow_avg mismatch, expected %h actual %h",
                             $time, exp_res.slow_avg, o_out_data.slow_avg);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // input side and config port
    // ------------------------------------------------------------------

    // one bar transfer; valid stays up when the next bar follows at once
    task automatic send_bar(input logic [31:0] price, input logic pos);
        macs_pkg::t_in_item bar;
        bar.close_price = price;
        bar.pos_held = pos;
        i_in_valid <= 1'b1;
        i_in_data <= bar;
        do @(posedge i_clk); while (o_in_stall);
        predict_crossover(bar);
        bars_sent++;
        // random gap, so the next bar lands at varying points in the block's work
        if (gaps_enabled && $urandom_range(99) < 9) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 120)) @(posedge i_clk);
        end
    endtask

    // drop valid and let every pending result come back
    task automatic wait_idle(input int unsigned extra);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input bit [6:0] value);
        // setup phase, upper data bits are junk the register must ignore
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {25'($urandom_range(32'h01FF_FFFF)), value};
        @(posedge i_clk);
        // access phase
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_FAST) fast_len_reg = value;
        else fast_len_reg = fast_len_reg;
        if (addr == ADDR_SLOW) slow_len_reg = value;
        period_writes++;
        @(posedge i_clk);
    endtask

    task automatic set_periods(input bit [6:0] fast_len, input bit [6:0] slow_len);
        wait_idle(4);
        write_reg(ADDR_FAST, fast_len);
        write_reg(ADDR_SLOW, slow_len);
    endtask

    // mostly legal windows, sometimes zero or past the ring depth
    function automatic bit [6:0] random_period();
        if ($urandom_range(99) < 85) return 7'($urandom_range(1, RING_DEPTH));
        if ($urandom_range(1)) return 7'd0;
        return 7'($urandom_range(RING_DEPTH + 1, 127));
    endfunction

    // price walk with trend runs sized to the slow window so that the
    // averages cross; a few full-range and extreme prices as noise
    task automatic stream_bars(input int unsigned count, input longint lo,
                               input longint hi);
        longint      level, span, step_max, step;
        bit          rising;
        int unsigned run_left;
        logic [31:0] price;
        logic        pos;
        int unsigned pick;
        span = hi - lo;
        level = lo + longint'($urandom_range(32'(span)));
        step_max = span / 8 + 1;
        if (step_max > 64'hFFFF_FFFF) step_max = 64'hFFFF_FFFF;
        rising = $urandom_range(1);
        run_left = $urandom_range(2, 2 * eff_len(slow_len_reg) + 2);
        for (int unsigned n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                price = $urandom;
            end else if (pick < 7) begin
                price = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            end else begin
                step = longint'($urandom_range(32'(step_max)));
                level = rising ? level + step : level - step;
                if (level > hi) level = hi;
                if (level < lo) level = lo;
                price = level[31:0];
                run_left--;
                if (run_left == 0) begin
                    rising = !rising;
                    run_left = $urandom_range(2, 2 * eff_len(slow_len_reg) + 2);
                end
            end
            // mostly a position that follows the signals, sometimes not
            pos = ($urandom_range(99) < 75) ? holding_now : 1'($urandom_range(1));
            send_bar(price, pos);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // a few bars at the reset windows, then hand-made crosses at windows 1/2
    task automatic test_signal_rules();
        for (int k = 1; k <= 6; k++) send_bar(32'h0000_0100 * k, k[0]);
        set_periods(7'd1, 7'd2);
        send_bar(32'd100, 1'b0);
        send_bar(32'd50, 1'b0);
        send_bar(32'd200, 1'b0);          // buy while flat
        send_bar(32'd10, 1'b0);           // sell while flat becomes hold
        send_bar(32'd300, 1'b1);          // buy while holding becomes hold
        send_bar(32'd5, 1'b1);            // sell
        send_bar(32'd400, 1'b0);          // buy
        send_bar(32'd500, 1'b1);          // no cross
        send_bar(32'd20, 1'b1);           // sell
        send_bar(32'd600, 1'b1);          // buy filtered by position
        send_bar(32'd1, 1'b1);            // repeated sell becomes hold
        send_bar(32'hFFFF_FFFF, 1'b0);    // top price
        send_bar(32'h0, 1'b1);            // zero price
        send_bar(32'hFFFF_FFFF, 1'b1);
        send_bar(32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_default_windows();
        set_periods(macs_pkg::FAST_LEN_RST, macs_pkg::SLOW_LEN_RST);
        stream_bars(200, 0, 32'h0010_0000);
    endtask

    // zero and oversized periods, then both windows at full depth
    task automatic test_window_extremes();
        set_periods(7'd0, 7'd127);
        stream_bars(150, 32'hF000_0000, 32'hFFFF_FFFF);
        set_periods(7'd64, 7'd64);
        stream_bars(100, 0, 32'hFFFF_FFFF);
    endtask

    task automatic test_fast_not_below_slow();
        set_periods(7'd30, 7'd7);
        stream_bars(60, 0, 32'h0000_FFFF);
        set_periods(7'd12, 7'd12);
        stream_bars(60, 0, 50);
    endtask

    // history and stored averages carry over each period change
    task automatic test_midstream_changes();
        for (int s = 0; s < 15; s++) begin
            set_periods(random_period(), random_period());
            stream_bars(20, 0, 32'h0004_0000);
        end
    endtask

    // output held off long enough for the block to stall its input
    task automatic test_output_backpressure();
        set_periods(random_period(), random_period());
        long_hold_request = 1'b1;
        stream_bars(150, 0, 32'h0100_0000);
    endtask

    task automatic test_no_idle_stretch();
        set_periods(7'd3, 7'd10);
        gaps_enabled = 1'b0;
        stream_bars(250, 0, 32'h0000_4000);
        gaps_enabled = 1'b1;
    endtask

    // random windows over tiny, mid, full and top price ranges; the tiny
    // range gives equal averages and exercises the non-strict compares
    task automatic test_random_mix();
        for (int s = 0; s < 6; s++) begin
            set_periods(random_period(), random_period());
            case ($urandom_range(3))
                0: stream_bars(100, 0, 64);
                1: stream_bars(100, 32'h0001_0000, 32'h0100_0000);
                2: stream_bars(100, 0, 32'hFFFF_FFFF);
                default: stream_bars(100, 32'hFF00_0000, 32'hFFFF_FFFF);
            endcase
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        last_trade = macs_pkg::SIG_NONE;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_signal_rules();
        test_default_windows();
        test_window_extremes();
        test_fast_not_below_slow();
        test_midstream_changes();
        test_output_backpressure();
        test_no_idle_stretch();
        test_random_mix();

        wait_idle(SETTLE_CYCLES);
        $display("bars %0d, results %0d: buy %0d, sell %0d, hold %0d, none %0d",
                 bars_sent, results_seen, n_buy, n_sell, n_hold, n_none);
        $display("%0d period writes incl. zero, 127, equal and fast above slow; %0s",
                 period_writes, "one long output hold");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #6_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
